### rtl/hra_pkg.sv
// Shared types, constants and codes of the hinted range allocator.
package hra_pkg;

  localparam int AddrWidth = 32;
  localparam int Entries   = 16;
  localparam int IdxWidth  = $clog2(Entries);
  localparam int CntWidth  = $clog2(Entries + 1);
  localparam int RowWidth  = 2 * AddrWidth;

  localparam logic CMD_MAP   = 1'b0;
  localparam logic CMD_UNMAP = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic        command;
    logic [31:0] address;
    logic [31:0] length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_address;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIT_START,
    S_FIT_RD,
    S_FIT_CHK,
    S_NEXT_CAND,
    S_CAND_RD,
    S_CAND_CHK,
    S_MAP_DONE,
    S_UNMAP_RD,
    S_UNMAP_CHK,
    S_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       cand_lo;
    logic       cand_ent;
    logic       cand_eval;
    logic       j_clr;
    logic       j_inc;
    logic       c_inc;
    logic       rd_en;
    logic       rd_sel_c;
    logic       fit_pass;
    logic       commit_map;
    logic       commit_unmap;
    logic       set_st;
    logic [1:0] st;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic unmap;
    logic addr_zero;
    logic len_zero;
    logic full;
    logic cand_ok;
    logic j_last;
    logic c_done;
    logic fit_hit;
    logic cand_use;
    logic unmap_hit;
    logic found;
  } ctrl_sts_t;

endpackage

### rtl/hra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hra_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/hra_ctrl.sv
// Controller state machine: sequences candidate search, fit scans and unmap lookup.
module hra_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output hra_pkg::ctrl_cmd_t cmd_o,
  input  hra_pkg::ctrl_sts_t sts_i
);
  import hra_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (sts_i.unmap) begin
          state_d = sts_i.addr_zero ? S_RESP : S_UNMAP_RD;
        end else if (sts_i.len_zero || sts_i.full) begin
          state_d = S_RESP;
        end else begin
          state_d = S_FIT_START;
        end
      end
      S_FIT_START: state_d = sts_i.cand_ok ? S_FIT_RD : S_NEXT_CAND;
      S_FIT_RD:    state_d = S_FIT_CHK;
      S_FIT_CHK: begin
        if (sts_i.fit_hit || sts_i.j_last) state_d = S_NEXT_CAND;
        else state_d = S_FIT_RD;
      end
      S_NEXT_CAND: state_d = sts_i.c_done ? S_MAP_DONE : S_CAND_RD;
      S_CAND_RD:   state_d = S_CAND_CHK;
      S_CAND_CHK:  state_d = sts_i.cand_use ? S_FIT_START : S_NEXT_CAND;
      S_MAP_DONE:  state_d = S_RESP;
      S_UNMAP_RD:  state_d = S_UNMAP_CHK;
      S_UNMAP_CHK: begin
        if (sts_i.unmap_hit || sts_i.j_last) state_d = S_RESP;
        else state_d = S_UNMAP_RD;
      end
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o  = '0;
    busy   = (state_q != S_IDLE);
    done_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = start;
      end
      S_DECODE: begin
        cmd_o.j_clr = 1'b1;
        if (sts_i.unmap) begin
          if (sts_i.addr_zero) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = ST_NOTFOUND;
          end
        end else if (sts_i.len_zero) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_NOFIT;
        end else if (sts_i.full) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_FULL;
        end else begin
          cmd_o.cand_lo = 1'b1;
        end
      end
      S_FIT_START: begin
        cmd_o.cand_eval = 1'b1;
        cmd_o.j_clr     = 1'b1;
      end
      S_FIT_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      S_FIT_CHK: begin
        if (!sts_i.fit_hit) begin
          if (sts_i.j_last) cmd_o.fit_pass = 1'b1;
          else cmd_o.j_inc = 1'b1;
        end
      end
      S_NEXT_CAND: begin
      end
      S_CAND_RD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel_c = 1'b1;
      end
      S_CAND_CHK: begin
        cmd_o.c_inc    = 1'b1;
        cmd_o.cand_ent = sts_i.cand_use;
      end
      S_MAP_DONE: begin
        cmd_o.set_st     = 1'b1;
        cmd_o.st         = sts_i.found ? ST_OK : ST_NOFIT;
        cmd_o.commit_map = sts_i.found;
      end
      S_UNMAP_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      S_UNMAP_CHK: begin
        if (sts_i.unmap_hit) begin
          cmd_o.commit_unmap = 1'b1;
          cmd_o.set_st       = 1'b1;
          cmd_o.st           = ST_OK;
        end else if (sts_i.j_last) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_NOTFOUND;
        end else begin
          cmd_o.j_inc = 1'b1;
        end
      end
      S_RESP: begin
        done_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/hra_dpath.sv
// Datapath: range table, valid bits, candidate and overlap arithmetic, result registers.
module hra_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hra_pkg::req_t      req_i,
  input  hra_pkg::ctrl_cmd_t cmd_i,
  output hra_pkg::ctrl_sts_t sts_o,
  output hra_pkg::rsp_t      rsp_o
);
  import hra_pkg::*;

  logic                 unmap_q;
  logic [AddrWidth-1:0] addr_q, lo_q, len_q;
  logic [AddrWidth-1:0] cand_q, cand_last_q, best_q, best_last_q;
  logic                 found_q;
  logic [IdxWidth-1:0]  j_q;
  logic [CntWidth-1:0]  c_q, count_q;
  logic [Entries-1:0]   valid_q;
  logic [1:0]           status_q;
  logic [AddrWidth-1:0] granted_q;

  logic [RowWidth-1:0]  rd_data;
  logic [AddrWidth-1:0] rd_start, rd_last;
  logic [IdxWidth-1:0]  rd_idx, c_idx, free_idx;
  logic [AddrWidth:0]   cand_sum;
  logic [AddrWidth-1:0] ent_next;
  logic                 overlap, ent_useful;

  assign c_idx    = c_q[IdxWidth-1:0];
  assign rd_idx   = cmd_i.rd_sel_c ? c_idx : j_q;
  assign rd_start = rd_data[RowWidth-1:AddrWidth];
  assign rd_last  = rd_data[AddrWidth-1:0];

  // Table rows hold {start, last byte}
  hra_ram #(
    .Width(RowWidth),
    .Depth(Entries)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit_map),
    .waddr_i(free_idx),
    .wdata_i({best_q, best_last_q}),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_idx),
    .rdata_o(rd_data)
  );

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IdxWidth'(i);
    end
  end

  // Candidate end and wrap check
  assign cand_sum = {1'b0, cand_q} + {1'b0, len_q} - {{AddrWidth{1'b0}}, 1'b1};

  // Overlap of candidate against the entry just read
  assign overlap = (cand_q <= rd_last) && (rd_start <= cand_last_q);

  // Entry end as a new candidate: not at the top, at or above lo, below best so far
  assign ent_next   = rd_last + {{(AddrWidth-1){1'b0}}, 1'b1};
  assign ent_useful = (rd_last != {AddrWidth{1'b1}}) && (ent_next >= lo_q) &&
                      (!found_q || (ent_next < best_q));

  // Request and search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      unmap_q <= req_i.command;
      addr_q  <= req_i.address;
      len_q   <= req_i.length;
      lo_q    <= (req_i.address == '0) ? {{(AddrWidth-1){1'b0}}, 1'b1} : req_i.address;
    end
    if (cmd_i.cand_lo) cand_q <= lo_q;
    else if (cmd_i.cand_ent) cand_q <= ent_next;
    if (cmd_i.cand_eval) begin
      cand_last_q <= cand_sum[AddrWidth-1:0];
    end
    if (cmd_i.fit_pass) begin
      best_q      <= cand_q;
      best_last_q <= cand_last_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      j_q       <= '0;
      c_q       <= '0;
      count_q   <= '0;
      valid_q   <= '0;
      status_q  <= ST_OK;
      granted_q <= '0;
    end else begin
      if (cmd_i.load) begin
        found_q   <= 1'b0;
        c_q       <= '0;
        status_q  <= ST_OK;
        granted_q <= '0;
      end
      if (cmd_i.fit_pass) found_q <= 1'b1;
      if (cmd_i.j_clr) j_q <= '0;
      else if (cmd_i.j_inc) j_q <= j_q + 1'b1;
      if (cmd_i.c_inc) c_q <= c_q + 1'b1;
      if (cmd_i.set_st) status_q <= cmd_i.st;
      if (cmd_i.commit_map) begin
        valid_q[free_idx] <= 1'b1;
        count_q           <= count_q + 1'b1;
        granted_q         <= best_q;
      end
      if (cmd_i.commit_unmap) begin
        valid_q[j_q] <= 1'b0;
        count_q      <= count_q - 1'b1;
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.unmap     = (unmap_q == CMD_UNMAP);
    sts_o.addr_zero = (addr_q == '0);
    sts_o.len_zero  = (len_q == '0);
    sts_o.full      = (count_q == CntWidth'(Entries));
    sts_o.cand_ok   = !cand_sum[AddrWidth];
    sts_o.j_last    = (j_q == IdxWidth'(Entries - 1));
    sts_o.c_done    = (c_q == CntWidth'(Entries));
    sts_o.fit_hit   = valid_q[j_q] && overlap;
    sts_o.cand_use  = valid_q[c_idx] && ent_useful;
    sts_o.unmap_hit = valid_q[j_q] && (rd_start == addr_q);
    sts_o.found     = found_q;
  end

  assign rsp_o.status          = status_q;
  assign rsp_o.granted_address = granted_q;

  // Fill count tracks the valid bits
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntWidth'($countones(valid_q)))
    else $error("entry count differs from valid bits");

  // A range is stored only into a table that has room
  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_map |-> (count_q != CntWidth'(Entries)) && found_q)
    else $error("map commit without room or grant");

  // Unmap removes only a valid entry
  a_unmap_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_unmap |-> valid_q[j_q] && (addr_q != '0))
    else $error("unmap of an invalid entry");

endmodule

### rtl/hinted_range_allocator_core.sv
// Top level of the hinted range allocator: controller plus datapath.
//
// Commands transfer when start is high and busy is low; each command gives one
// result, shown on result_o for one cycle with done_o high, which the receiver
// must take then. An unmap walks the table entry by entry until it finds the
// address or reaches the last entry. A map tests the hint and then each stored
// range end as a candidate; each useful candidate costs a fit scan of the table
// through its single read port, which stops at the first overlap. Failed checks
// (zero length, full table, unmap of address zero) answer straight after decode.
module hinted_range_allocator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  hra_pkg::req_t req_i,
  output logic          done_o,
  output hra_pkg::rsp_t result_o
);
  import hra_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  hra_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .done_o(done_o),
    .cmd_o (cmd),
    .sts_i (sts)
  );

  hra_dpath u_dpath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (result_o)
  );

endmodule

### verif/testbench.sv
// Self-checking testbench of the hinted range allocator core.
module testbench;
  import hra_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int MaxErrReports = 10;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  logic  busy;
  req_t  req_i;
  logic  done_o;
  rsp_t  result_o;

  hinted_range_allocator_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // Shadow allocation table
  bit          tbl_valid [Entries];
  logic [31:0] tbl_start [Entries];
  logic [31:0] tbl_len   [Entries];
  int          tbl_count;

  req_t pending_cmds[$];
  rsp_t expected_rsps[$];
  int   mismatch_count;
  int   stall_cycles;
  bit   stim_done;

  // True if [a, a+len) stays below the top and hits no stored range
  function automatic bit range_free(logic [31:0] a, logic [31:0] len);
    logic [32:0] last;
    logic [32:0] s_last;
    if ({1'b0, a} + {1'b0, len} - 33'd1 > 33'hFFFF_FFFF) return 1'b0;
    last = {1'b0, a} + {1'b0, len} - 33'd1;
    for (int i = 0; i < Entries; i++) begin
      if (!tbl_valid[i]) continue;
      s_last = {1'b0, tbl_start[i]} + {1'b0, tbl_len[i]} - 33'd1;
      if ({1'b0, a} <= s_last && {1'b0, tbl_start[i]} <= last) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Computes the response of one command and updates the shadow table
  function automatic rsp_t alloc_predict(req_t cmd);
    rsp_t        r;
    logic [31:0] lo;
    logic [31:0] best;
    logic [32:0] s_last;
    bit          found;
    r.status = ST_OK;
    r.granted_address = '0;
    if (cmd.command == CMD_MAP) begin
      if (cmd.length == 0) begin
        r.status = ST_NOFIT;
      end else if (tbl_count >= Entries) begin
        r.status = ST_FULL;
      end else begin
        lo = (cmd.address == 0) ? 32'd1 : cmd.address;
        found = range_free(lo, cmd.length);
        best = lo;
        for (int i = 0; i < Entries; i++) begin
          if (!tbl_valid[i]) continue;
          s_last = {1'b0, tbl_start[i]} + {1'b0, tbl_len[i]} - 33'd1;
          if (s_last >= 33'hFFFF_FFFF) continue;
          if (s_last[31:0] + 32'd1 < lo) continue;
          if (found && s_last[31:0] + 32'd1 >= best) continue;
          if (range_free(s_last[31:0] + 32'd1, cmd.length)) begin
            found = 1'b1;
            best = s_last[31:0] + 32'd1;
          end
        end
        if (!found) begin
          r.status = ST_NOFIT;
        end else begin
          for (int i = 0; i < Entries; i++) begin
            if (!tbl_valid[i]) begin
              tbl_valid[i] = 1'b1;
              tbl_start[i] = best;
              tbl_len[i] = cmd.length;
              tbl_count++;
              break;
            end
          end
          r.granted_address = best;
        end
      end
    end else begin
      r.status = ST_NOTFOUND;
      if (cmd.address != 0) begin
        for (int i = 0; i < Entries; i++) begin
          if (tbl_valid[i] && tbl_start[i] == cmd.address) begin
            tbl_valid[i] = 1'b0;
            tbl_count--;
            r.status = ST_OK;
            break;
          end
        end
      end
    end
    return r;
  endfunction

  // Queue of granted starts, declared but not read; aimed unmaps use the shadow table
  logic [31:0] live_starts[$];

  function automatic req_t mk_cmd(logic c, logic [31:0] a, logic [31:0] l);
    req_t q;
    q.command = c;
    q.address = a;
    q.length = l;
    return q;
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2:       return 32'd0;
      default: return $urandom_range(1, 32'h0400_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_addr();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      2:       return $urandom();
      default: return $urandom_range(0, 32'h2000_0000);
    endcase
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stimulus: directed corners, then mostly map/unmap sequences
  initial begin
    int pick;
    rst_ni = 1'b0;
    pending_cmds.push_back(mk_cmd(CMD_UNMAP, 32'd0, 32'd5));
    pending_cmds.push_back(mk_cmd(CMD_MAP, 32'd0, 32'd0));
    pending_cmds.push_back(mk_cmd(CMD_MAP, 32'd0, 32'h10));
    pending_cmds.push_back(mk_cmd(CMD_MAP, 32'd0, 32'h10));
    pending_cmds.push_back(mk_cmd(CMD_MAP, 32'h8, 32'h4));
    pending_cmds.push_back(mk_cmd(CMD_MAP, 32'hFFFF_FFFF, 32'd1));
    pending_cmds.push_back(mk_cmd(CMD_MAP, 32'hFFFF_FFF0, 32'h20));
    pending_cmds.push_back(mk_cmd(CMD_MAP, 32'd1, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk_cmd(CMD_UNMAP, 32'h11, 32'hFFFF_FFFF));
    pending_cmds.push_back(mk_cmd(CMD_UNMAP, 32'h11, 32'd0));
    pending_cmds.push_back(mk_cmd(CMD_UNMAP, 32'h1, 32'd0));
    pending_cmds.push_back(mk_cmd(CMD_UNMAP, 32'hFFFF_FFFF, 32'd0));
    for (int i = 0; i < 17; i++)
      pending_cmds.push_back(mk_cmd(CMD_MAP, 32'h100 * i, 32'h80));
    for (int i = 0; i < 1550; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        pending_cmds.push_back(mk_cmd(CMD_MAP, rand_addr(), rand_len()));
      end else if (pick < 55) begin
        pending_cmds.push_back(mk_cmd(CMD_UNMAP, rand_addr(), $urandom()));
      end else begin
        // aimed unmap: resolved against the table when driven
        pending_cmds.push_back(mk_cmd(CMD_UNMAP, 32'd0, 32'hA5A5_0001));
      end
    end
    stim_done = 1'b1;
  end

  // Driver: one command per transfer, with random gaps between commands
  int   gap_left;
  req_t next_cmd;
  int   hit_idx;
  initial begin
    start = 1'b0;
    req_i = '0;
    gap_left = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        // command finished and the core is idle again
        start <= 1'b0;
        gap_left = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap_left = 0;
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          next_cmd = pending_cmds.pop_front();
          if (next_cmd.command == CMD_UNMAP && next_cmd.length == 32'hA5A5_0001) begin
            // pick a live range start from the shadow table, if any
            hit_idx = $urandom_range(0, Entries - 1);
            for (int k = 0; k < Entries; k++) begin
              if (tbl_valid[(hit_idx + k) % Entries]) begin
                next_cmd.address = tbl_start[(hit_idx + k) % Entries];
                break;
              end
            end
            next_cmd.length = $urandom();
          end
          req_i <= next_cmd;
          start <= 1'b1;
        end
      end
    end
  end

  // Prediction at each accepted transfer; monitor of results; watchdog
  rsp_t exp_rsp;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (start && !busy) begin
        expected_rsps.push_back(alloc_predict(req_i));
      end
      if (done_o) begin
        if (expected_rsps.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxErrReports)
            $display("unexpected result status=%0d addr=%h",
                     result_o.status, result_o.granted_address);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (result_o.status !== exp_rsp.status ||
              result_o.granted_address !== exp_rsp.granted_address) begin
            mismatch_count++;
            if (mismatch_count <= MaxErrReports)
              $display("mismatch: exp status=%0d addr=%h, got status=%0d addr=%h",
                       exp_rsp.status, exp_rsp.granted_address,
                       result_o.status, result_o.granted_address);
          end
        end
      end
    end
  end

  // End of run
  initial begin
    mismatch_count = 0;
    stall_cycles = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_cycles >= WatchdogLimit) begin
        $display("[hinted_range_allocator_core] ERROR");
        $finish;
      end
      if (stim_done && pending_cmds.size() == 0 && !start &&
          expected_rsps.size() == 0 && !busy) begin
        repeat (20) @(posedge clk_i);
        if (mismatch_count == 0) begin
          $display("[hinted_range_allocator_core] OK");
        end else begin
          $display("[hinted_range_allocator_core] ERROR");
        end
        $finish;
      end
    end
  end

endmodule
